FILE: src/qme_pkg.sv
package qme_pkg;

   // Item commands
   localparam logic CMD_MOTION = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERT_X      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERT_Y      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SWAP_XY       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BACKLOG_LIMIT = 3'd3;

   // Field widths
   localparam int unsigned DELTA_W   = 16;
   localparam int unsigned LIMIT_W   = 7;
   localparam int unsigned BACKLOG_W = 8;
   localparam int unsigned PHASE_W   = 2;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd20;

   // Quadrature line tables, bit n is the line level at phase n
   localparam logic [3:0] LINE_A_TAB = 4'b1100;
   localparam logic [3:0] LINE_B_TAB = 4'b0110;

   typedef struct packed {
      logic               invert_x;
      logic               invert_y;
      logic               swap_xy;
      logic [LIMIT_W-1:0] limit;
   } cfg_type;

   // Next-state view of one axis, taken into the result register
   typedef struct packed {
      logic line_a;
      logic line_b;
      logic nonzero;
   } axis_status_type;

endpackage

FILE: src/quadrature_mouse_emitter_top.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  req_command, req_delta_x, req_delta_y
// rsp_      out        rsp_valid / rsp_stall  rsp_x/y_phase_a/b, rsp_activity
// csr_      in         csr_valid / csr_ready  csr_index, csr_wdata
//
// One item per cycle sustained while rsp_stall is low; an item's result passes the
// input register, then the result register, before it shows on rsp_.
// Reset clears both axis backlogs and phases and restores the registers
// (backlog limit 20). A stalled result holds; one more item waits in the input
// register, after which req_stall rises.
module quadrature_mouse_emitter_top (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic                                      req_command,
   input  logic signed [qme_pkg::DELTA_W-1:0]        req_delta_x,
   input  logic signed [qme_pkg::DELTA_W-1:0]        req_delta_y,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic                                      rsp_x_phase_a,
   output logic                                      rsp_x_phase_b,
   output logic                                      rsp_y_phase_a,
   output logic                                      rsp_y_phase_b,
   output logic                                      rsp_activity,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [qme_pkg::CSR_INDEX_W-1:0]           csr_index,
   input  logic [qme_pkg::LIMIT_W-1:0]               csr_wdata
);

   qme_pkg::cfg_type         cfg;
   qme_pkg::axis_status_type x_status;
   qme_pkg::axis_status_type y_status;

   logic                                s1_valid_ff;
   logic                                s1_valid_in;
   logic                                s1_command_ff;
   logic signed [qme_pkg::DELTA_W-1:0]  s1_dx_ff;
   logic signed [qme_pkg::DELTA_W-1:0]  s1_dy_ff;

   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic rsp_x_phase_a_ff;
   logic rsp_x_phase_b_ff;
   logic rsp_y_phase_a_ff;
   logic rsp_y_phase_b_ff;
   logic rsp_activity_ff;

   logic take_req;
   logic advance;
   logic is_tick;

   logic signed [qme_pkg::DELTA_W:0] dx_ext;
   logic signed [qme_pkg::DELTA_W:0] dy_ext;
   logic signed [qme_pkg::DELTA_W:0] dx_inv;
   logic signed [qme_pkg::DELTA_W:0] dy_inv;
   logic signed [qme_pkg::DELTA_W:0] x_delta;
   logic signed [qme_pkg::DELTA_W:0] y_delta;

   qme_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Handshake: advance when the result register is free or being drained
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign take_req  = req_valid && !req_stall;

   assign s1_valid_in  = take_req || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   // Capture the input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         s1_command_ff <= req_command;
         s1_dx_ff      <= req_delta_x;
         s1_dy_ff      <= req_delta_y;
      end
   end

   // Invert in a wider word so the most negative delta negates cleanly, then swap
   assign is_tick = (s1_command_ff == qme_pkg::CMD_TICK);
   assign dx_ext  = {s1_dx_ff[qme_pkg::DELTA_W-1], s1_dx_ff};
   assign dy_ext  = {s1_dy_ff[qme_pkg::DELTA_W-1], s1_dy_ff};
   assign dx_inv  = cfg.invert_x ? -dx_ext : dx_ext;
   assign dy_inv  = cfg.invert_y ? -dy_ext : dy_ext;
   assign x_delta = cfg.swap_xy ? dy_inv : dx_inv;
   assign y_delta = cfg.swap_xy ? dx_inv : dy_inv;

   qme_axis u_axis_x (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .is_tick (is_tick),
      .delta   (x_delta),
      .limit   (cfg.limit),
      .status  (x_status)
   );

   qme_axis u_axis_y (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .is_tick (is_tick),
      .delta   (y_delta),
      .limit   (cfg.limit),
      .status  (y_status)
   );

   // Result register: load on advance, hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_x_phase_a_ff <= x_status.line_a;
         rsp_x_phase_b_ff <= x_status.line_b;
         rsp_y_phase_a_ff <= y_status.line_a;
         rsp_y_phase_b_ff <= y_status.line_b;
         rsp_activity_ff  <= !is_tick && (x_status.nonzero || y_status.nonzero);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_x_phase_a = rsp_x_phase_a_ff;
   assign rsp_x_phase_b = rsp_x_phase_b_ff;
   assign rsp_y_phase_a = rsp_y_phase_a_ff;
   assign rsp_y_phase_b = rsp_y_phase_b_ff;
   assign rsp_activity  = rsp_activity_ff;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("input stalled with room in the pipeline");

   a_advance_fills_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced item did not reach the result register");

   a_tick_no_activity: assert property (@(posedge clock) disable iff (reset)
      advance && is_tick |=> !rsp_activity_ff)
      else $error("tick item reported activity");

endmodule

FILE: src/qme_csr.sv
module qme_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [qme_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [qme_pkg::LIMIT_W-1:0]      csr_wdata,
   output qme_pkg::cfg_type                 cfg
);

   qme_pkg::cfg_type cfg_ff;
   qme_pkg::cfg_type cfg_in;

   // Always ready: a write lands in the config register at the next clock edge
   assign csr_ready = 1'b1;

   // Decode the register index, drop writes beyond the list
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            qme_pkg::CSR_INVERT_X:      cfg_in.invert_x = csr_wdata[0];
            qme_pkg::CSR_INVERT_Y:      cfg_in.invert_y = csr_wdata[0];
            qme_pkg::CSR_SWAP_XY:       cfg_in.swap_xy  = csr_wdata[0];
            qme_pkg::CSR_BACKLOG_LIMIT: cfg_in.limit    = csr_wdata;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.invert_x <= 1'b0;
         cfg_ff.invert_y <= 1'b0;
         cfg_ff.swap_xy  <= 1'b0;
         cfg_ff.limit    <= qme_pkg::LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: src/qme_axis.sv
module qme_axis (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic                                is_tick,
   input  logic signed [qme_pkg::DELTA_W:0]    delta,
   input  logic [qme_pkg::LIMIT_W-1:0]         limit,
   output qme_pkg::axis_status_type            status
);

   localparam int unsigned SUM_W = qme_pkg::DELTA_W + 2;

   logic signed [qme_pkg::BACKLOG_W-1:0] backlog_ff;
   logic signed [qme_pkg::BACKLOG_W-1:0] backlog_in;
   logic        [qme_pkg::PHASE_W-1:0]   phase_ff;
   logic        [qme_pkg::PHASE_W-1:0]   phase_in;

   logic signed [SUM_W-1:0] sum;
   logic signed [SUM_W-1:0] lim_pos;
   logic signed [SUM_W-1:0] lim_neg;

   // Add the delta to the backlog in a wide sum so nothing wraps
   assign sum = $signed({{(SUM_W-qme_pkg::BACKLOG_W){backlog_ff[qme_pkg::BACKLOG_W-1]}},
                         backlog_ff})
              + $signed({delta[qme_pkg::DELTA_W], delta});
   assign lim_pos = $signed({{(SUM_W-qme_pkg::LIMIT_W){1'b0}}, limit});
   assign lim_neg = -lim_pos;

   // Saturate on motion, drain one step toward zero on a tick
   always_comb begin
      backlog_in = backlog_ff;
      phase_in   = phase_ff;
      if (advance) begin
         if (is_tick) begin
            if (backlog_ff > 0) begin
               backlog_in = backlog_ff - 8'sd1;
               phase_in   = phase_ff - 2'd1;
            end else if (backlog_ff < 0) begin
               backlog_in = backlog_ff + 8'sd1;
               phase_in   = phase_ff + 2'd1;
            end
         end else if (sum > lim_pos) begin
            backlog_in = lim_pos[qme_pkg::BACKLOG_W-1:0];
         end else if (sum < lim_neg) begin
            backlog_in = lim_neg[qme_pkg::BACKLOG_W-1:0];
         end else begin
            backlog_in = sum[qme_pkg::BACKLOG_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         backlog_ff <= '0;
         phase_ff   <= '0;
      end else begin
         backlog_ff <= backlog_in;
         phase_ff   <= phase_in;
      end
   end

   // Report the lines and backlog state as they stand after this item
   assign status.line_a  = qme_pkg::LINE_A_TAB[phase_in];
   assign status.line_b  = qme_pkg::LINE_B_TAB[phase_in];
   assign status.nonzero = (backlog_in != '0);

   a_backlog_in_range: assert property (@(posedge clock) disable iff (reset)
      backlog_ff != 8'sh80)
      else $error("backlog reached the most negative code");

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(backlog_ff) && $stable(phase_ff))
      else $error("axis state moved without a transfer");

   a_tick_positive_steps_down: assert property (@(posedge clock) disable iff (reset)
      advance && is_tick && (backlog_ff > 0) |=>
         (phase_ff == $past(phase_ff) - 2'd1) && (backlog_ff == $past(backlog_ff) - 8'sd1))
      else $error("positive backlog did not drain by one step");

endmodule

FILE: tb/tb_quadrature_mouse_emitter_top.sv
`timescale 1ns / 1ps

module tb_quadrature_mouse_emitter_top;

   // Levels of the four quadrature lines and the activity flag for one result
   typedef struct packed {
      logic x_a;
      logic x_b;
      logic y_a;
      logic y_b;
      logic activity;
   } quad_lines_type;

   // Tracks backlogs, phases and settings; holds the line levels still to come
   class quad_scoreboard;
      bit                                inv_x;
      bit                                inv_y;
      bit                                swap_axes;
      logic [qme_pkg::LIMIT_W-1:0]       limit;
      int                                x_backlog;
      int                                y_backlog;
      logic [qme_pkg::PHASE_W-1:0]       x_phase;
      logic [qme_pkg::PHASE_W-1:0]       y_phase;
      quad_lines_type                    expected_lines_q[$];
      int                                errors;

      function new();
         inv_x     = 1'b0;
         inv_y     = 1'b0;
         swap_axes = 1'b0;
         limit     = qme_pkg::LIMIT_RESET;
         x_backlog = 0;
         y_backlog = 0;
         x_phase   = '0;
         y_phase   = '0;
         errors    = 0;
      endfunction

      function int pending();
         return expected_lines_q.size();
      endfunction

      function void write_reg(logic [qme_pkg::CSR_INDEX_W-1:0] idx,
                              logic [qme_pkg::LIMIT_W-1:0] val);
         case (idx)
            qme_pkg::CSR_INVERT_X:      inv_x     = val[0];
            qme_pkg::CSR_INVERT_Y:      inv_y     = val[0];
            qme_pkg::CSR_SWAP_XY:       swap_axes = val[0];
            qme_pkg::CSR_BACKLOG_LIMIT: limit     = val;
            default: ;
         endcase
      endfunction

      function int clamp(int v, int bound);
         if (v > bound) return bound;
         if (v < -bound) return -bound;
         return v;
      endfunction

      // Move one unit toward zero; phase counts down for a positive backlog
      function void step_axis(inout int backlog, inout logic [qme_pkg::PHASE_W-1:0] phase);
         if (backlog > 0) begin
            backlog = backlog - 1;
            phase   = phase - 1'b1;
         end else if (backlog < 0) begin
            backlog = backlog + 1;
            phase   = phase + 1'b1;
         end
      endfunction

      function void apply_item(logic cmd, logic signed [qme_pkg::DELTA_W-1:0] dx_in,
                               logic signed [qme_pkg::DELTA_W-1:0] dy_in);
         int             dx;
         int             dy;
         int             held;
         quad_lines_type want;
         want = '0;
         if (cmd == qme_pkg::CMD_MOTION) begin
            // widen first so that negating the most negative delta does not wrap
            dx = dx_in;
            dy = dy_in;
            if (inv_x) dx = -dx;
            if (inv_y) dy = -dy;
            if (swap_axes) begin
               held = dx;
               dx   = dy;
               dy   = held;
            end
            x_backlog     = clamp(x_backlog + dx, int'(limit));
            y_backlog     = clamp(y_backlog + dy, int'(limit));
            want.activity = (x_backlog != 0) || (y_backlog != 0);
         end else begin
            step_axis(x_backlog, x_phase);
            step_axis(y_backlog, y_phase);
         end
         // Gray sequence 00,01,11,10 on the A and B lines
         want.x_a = x_phase[1];
         want.x_b = x_phase[1] ^ x_phase[0];
         want.y_a = y_phase[1];
         want.y_b = y_phase[1] ^ y_phase[0];
         expected_lines_q.push_back(want);
      endfunction

      task report_mismatch(string msg);
         $display("%0t ns: %s", $time, msg);
         errors++;
      endtask

      task compare_line(string field, logic got, logic want);
         if (got !== want)
            report_mismatch($sformatf("%s mismatch: got %b, expected %b", field, got, want));
      endtask

      task check_lines(quad_lines_type got);
         quad_lines_type want;
         if (expected_lines_q.size() == 0) begin
            report_mismatch($sformatf("result %b with no transfer outstanding", got));
            return;
         end
         want = expected_lines_q.pop_front();
         compare_line("x_phase_a", got.x_a, want.x_a);
         compare_line("x_phase_b", got.x_b, want.x_b);
         compare_line("y_phase_a", got.y_a, want.y_a);
         compare_line("y_phase_b", got.y_b, want.y_b);
         compare_line("activity", got.activity, want.activity);
      endtask
   endclass

   logic                                       clock;
   logic                                       reset;
   logic                                       req_valid;
   logic                                       req_stall;
   logic                                       req_command;
   logic signed [qme_pkg::DELTA_W-1:0]         req_delta_x;
   logic signed [qme_pkg::DELTA_W-1:0]         req_delta_y;
   logic                                       rsp_valid;
   logic                                       rsp_stall;
   logic                                       rsp_x_phase_a;
   logic                                       rsp_x_phase_b;
   logic                                       rsp_y_phase_a;
   logic                                       rsp_y_phase_b;
   logic                                       rsp_activity;
   logic                                       csr_valid;
   logic                                       csr_ready;
   logic [qme_pkg::CSR_INDEX_W-1:0]            csr_index;
   logic [qme_pkg::LIMIT_W-1:0]                csr_wdata;

   quad_scoreboard                             tracker;
   bit                                         calm;

   quadrature_mouse_emitter_top DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_delta_x   (req_delta_x),
      .req_delta_y   (req_delta_y),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_x_phase_a (rsp_x_phase_a),
      .rsp_x_phase_b (rsp_x_phase_b),
      .rsp_y_phase_a (rsp_y_phase_a),
      .rsp_y_phase_b (rsp_y_phase_b),
      .rsp_activity  (rsp_activity),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Check every result transfer against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_lines({rsp_x_phase_a, rsp_x_phase_b, rsp_y_phase_a,
                              rsp_y_phase_b, rsp_activity});
   end

   // Stall the result side in random bursts; hold off while calm
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11) - 1) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Present one motion report or tick and hold it until the transfer
   task automatic send_item(input logic cmd, input logic signed [qme_pkg::DELTA_W-1:0] dx,
                            input logic signed [qme_pkg::DELTA_W-1:0] dy);
      @(negedge clock);
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_delta_x <= dx;
      req_delta_y <= dy;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.apply_item(cmd, dx, dy);
      // random gap on the sender side
      if (!calm && $urandom_range(0, 7) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11) - 1) @(negedge clock);
      end
   endtask

   // Drop valid and wait until every result is back and the pipe is empty
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [qme_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [qme_pkg::LIMIT_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.write_reg(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly small moves so backlogs drain to zero often; some extremes and noise
   function automatic logic [qme_pkg::DELTA_W-1:0] pick_delta();
      int unsigned roll;
      int          v;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         v = int'($urandom_range(0, 16)) - 8;
      else if (roll < 80)
         v = int'($urandom_range(0, 400)) - 200;
      else if (roll < 93)
         v = $urandom;
      else begin
         case ($urandom_range(0, 3))
            0:       v = -32768;
            1:       v = 32767;
            2:       v = -1;
            default: v = 0;
         endcase
      end
      return v[qme_pkg::DELTA_W-1:0];
   endfunction

   // New random settings, with the limit extremes well represented
   task automatic random_config();
      logic [qme_pkg::LIMIT_W-1:0] lim;
      case ($urandom_range(0, 5))
         0:       lim = '0;
         1:       lim = 7'd1;
         2:       lim = 7'd127;
         default: lim = (qme_pkg::LIMIT_W)'($urandom_range(1, 127));
      endcase
      write_reg(qme_pkg::CSR_INVERT_X, (qme_pkg::LIMIT_W)'($urandom));
      write_reg(qme_pkg::CSR_INVERT_Y, (qme_pkg::LIMIT_W)'($urandom));
      write_reg(qme_pkg::CSR_SWAP_XY, (qme_pkg::LIMIT_W)'($urandom));
      write_reg(qme_pkg::CSR_BACKLOG_LIMIT, lim);
      if ($urandom_range(0, 2) == 0)
         write_reg((qme_pkg::CSR_INDEX_W)'($urandom_range(qme_pkg::CSR_BACKLOG_LIMIT + 1,
                                                          (1 << qme_pkg::CSR_INDEX_W) - 1)),
                   (qme_pkg::LIMIT_W)'($urandom));
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_command = qme_pkg::CMD_MOTION;
      req_delta_x = '0;
      req_delta_y = '0;
      csr_valid   = 1'b0;
      csr_index   = qme_pkg::CSR_INVERT_X;
      csr_wdata   = '0;
      calm        = 1'b0;
      tracker     = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: zero move, full-scale saturation, ticks ignoring deltas
      send_item(qme_pkg::CMD_MOTION, 16'sh0000, 16'sh0000);
      send_item(qme_pkg::CMD_MOTION, 16'sh7FFF, 16'sh8000);
      send_item(qme_pkg::CMD_TICK, 16'sh5A5A, 16'shA5A5);
      send_item(qme_pkg::CMD_TICK, 16'shFFFF, 16'sh8000);
      send_item(qme_pkg::CMD_MOTION, 16'sh8000, 16'sh7FFF);
      send_item(qme_pkg::CMD_MOTION, 16'sh0001, 16'shFFFF);
      send_item(qme_pkg::CMD_TICK, 16'sh0000, 16'sh0000);
      drain_results();

      // Invert and swap at the widest limit; negating the most negative delta
      write_reg(qme_pkg::CSR_INVERT_X, 7'h01);
      write_reg(qme_pkg::CSR_INVERT_Y, 7'h7F);
      write_reg(qme_pkg::CSR_SWAP_XY, 7'h01);
      write_reg(qme_pkg::CSR_BACKLOG_LIMIT, 7'd127);
      send_item(qme_pkg::CMD_MOTION, 16'sh8000, 16'sh0001);
      send_item(qme_pkg::CMD_MOTION, 16'sh7FFF, 16'sh8000);
      send_item(qme_pkg::CMD_TICK, 16'sh1234, 16'sh4321);
      send_item(qme_pkg::CMD_TICK, 16'sh0000, 16'sh0000);
      drain_results();

      // Lowered limit: ticks drain the old backlog, next report clamps it
      write_reg(qme_pkg::CSR_BACKLOG_LIMIT, 7'd3);
      send_item(qme_pkg::CMD_TICK, 16'sh0000, 16'sh0000);
      send_item(qme_pkg::CMD_TICK, 16'sh0000, 16'sh0000);
      send_item(qme_pkg::CMD_MOTION, 16'sh0000, 16'sh0000);
      send_item(qme_pkg::CMD_TICK, 16'sh0000, 16'sh0000);
      drain_results();

      // Zero limit swallows all motion; writes beyond the register list are ignored
      write_reg(qme_pkg::CSR_BACKLOG_LIMIT, 7'd0);
      for (int i = qme_pkg::CSR_BACKLOG_LIMIT + 1; i < (1 << qme_pkg::CSR_INDEX_W); i++)
         write_reg(i[qme_pkg::CSR_INDEX_W-1:0], 7'h7F);
      send_item(qme_pkg::CMD_MOTION, 16'sh0064, 16'shFF9C);
      send_item(qme_pkg::CMD_TICK, 16'sh0000, 16'sh0000);
      send_item(qme_pkg::CMD_MOTION, 16'sh8000, 16'sh8000);
      drain_results();

      // Smallest non-zero limit, flags cleared, two of them with bit 0 low and the rest set
      write_reg(qme_pkg::CSR_INVERT_X, 7'h7E);
      write_reg(qme_pkg::CSR_INVERT_Y, 7'h00);
      write_reg(qme_pkg::CSR_SWAP_XY, 7'h7E);
      write_reg(qme_pkg::CSR_BACKLOG_LIMIT, 7'd1);
      send_item(qme_pkg::CMD_MOTION, 16'sh0005, 16'shFFFB);
      send_item(qme_pkg::CMD_TICK, 16'sh0000, 16'sh0000);
      send_item(qme_pkg::CMD_TICK, 16'sh0000, 16'sh0000);
      send_item(qme_pkg::CMD_MOTION, 16'shFFFF, 16'sh0001);
      send_item(qme_pkg::CMD_TICK, 16'sh0000, 16'sh0000);
      drain_results();

      // Random phases; some without idling, the last one always so
      for (int phase_n = 0; phase_n < 6; phase_n++) begin
         random_config();
         calm = (phase_n == 2) || (phase_n == 5);
         for (int n = 0; n < 125; n++) begin
            if ($urandom_range(0, 99) < 45)
               send_item(qme_pkg::CMD_TICK, (qme_pkg::DELTA_W)'($urandom),
                         (qme_pkg::DELTA_W)'($urandom));
            else
               send_item(qme_pkg::CMD_MOTION, pick_delta(), pick_delta());
         end
         drain_results();
      end

      repeat (6) @(posedge clock);
      if (tracker.errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Hard stop well beyond the slowest legal run
   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

endmodule

FILE: quadrature_mouse_emitter_top.f
src/qme_pkg.sv
src/qme_csr.sv
src/qme_axis.sv
src/quadrature_mouse_emitter_top.sv
tb/tb_quadrature_mouse_emitter_top.sv
